### sv/bffa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator package
// Shared types, field widths and default sizes for the allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

  localparam int unsigned DEF_ROWS = 16;
  localparam int unsigned DEF_COLS = 16;

  localparam int unsigned ROW_IDX_W = 4;
  localparam int unsigned ROW_BITS_W = 16;
  localparam int unsigned SIZE_W = 9;
  localparam int unsigned POS_W = 4;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_ALLOC = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [ROW_IDX_W-1:0]  row_index;
    logic [ROW_BITS_W-1:0] row_bits;
    logic [SIZE_W-1:0]     request_size;
  } alloc_req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] start_row;
    logic [POS_W-1:0] start_column;
  } alloc_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MARK,
    ST_DONE
  } state_e;

endpackage

### sv/bitmap_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator
// Keeps a ROWS by COLS allocation bitmap in a circular shift register and
// searches it one bit per cycle for the first free run of a requested length.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                    Transfer
//   request   start, req_i, busy       start high and busy low at a clock edge
//   result    done_o, rsp_o            one cycle with done_o high, no stall
//
// A load transfer writes its row at the accepting edge; busy stays low.
// An allocate transfer rotates the bitmap once to search and, on a hit, once
// more to mark the run used; busy stays high through the search, through the
// mark pass on a hit and through the done state, which alone follows a bad size.
// The result is driven in the last busy cycle. Reset clears the whole bitmap.

module bitmap_first_fit_allocator
  import bffa_pkg::*;
#(
  parameter int unsigned ROWS = DEF_ROWS,
  parameter int unsigned COLS = DEF_COLS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  alloc_req_t req_i,
  output logic       busy,
  output logic       done_o,
  output alloc_rsp_t rsp_o
);

  localparam int unsigned TOTAL = ROWS * COLS;
  localparam int unsigned RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int unsigned CNT_W = $clog2(TOTAL + 1);
  localparam int unsigned CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

  state_e state_q, state_d;

  logic [TOTAL-1:0] map_q, map_d;
  logic [RW-1:0]    row_q, row_d;
  logic [CW-1:0]    col_q, col_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             hit_q, hit_d;
  logic             mark_q, mark_d;
  logic [RW-1:0]    srow_q, srow_d;
  logic [CW-1:0]    scol_q, scol_d;
  logic [RW-1:0]    erow_q, erow_d;
  logic [CW-1:0]    ecol_q, ecol_d;
  logic [SIZE_W-1:0] size_q, size_d;

  logic             accept;
  logic             last_pos;
  logic             at_start;
  logic             at_end;
  logic             in_run;
  logic             hit_now;
  logic             size_bad;
  logic [CMP_W-1:0] count_inc;
  logic [63:0]      row_wide;
  logic [COLS-1:0]  row_val;
  logic [63:0]      srow_wide;
  logic [63:0]      scol_wide;

  assign accept = start && !busy;
  assign last_pos = (row_q == RW'(ROWS - 1)) && (col_q == CW'(COLS - 1));
  assign at_start = (row_q == srow_q) && (col_q == scol_q);
  assign at_end = (row_q == erow_q) && (col_q == ecol_q);
  assign in_run = at_start || mark_q;
  assign count_inc = CMP_W'(count_q) + CMP_W'(1);
  assign hit_now = !hit_q && !map_q[0] && (count_inc == CMP_W'(size_q));
  assign size_bad = (req_i.request_size == '0)
                 || (CMP_W'(req_i.request_size) > CMP_W'(TOTAL));
  assign row_wide = 64'(req_i.row_bits);
  assign row_val = row_wide[COLS-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (req_i.kind == KIND_ALLOC)) begin
          state_d = size_bad ? ST_DONE : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (last_pos) begin
          state_d = (hit_q || hit_now) ? ST_MARK : ST_DONE;
        end
      end
      ST_MARK: begin
        if (last_pos) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_q != ST_IDLE);
    done_o = (state_q == ST_DONE);
  end

  always_comb begin
    map_d = map_q;
    row_d = row_q;
    col_d = col_q;
    count_d = count_q;
    hit_d = hit_q;
    mark_d = mark_q;
    srow_d = srow_q;
    scol_d = scol_q;
    erow_d = erow_q;
    ecol_d = ecol_q;
    size_d = size_q;

    if (state_q == ST_SEARCH || state_q == ST_MARK) begin
      if (last_pos) begin
        row_d = '0;
        col_d = '0;
      end else if (col_q == CW'(COLS - 1)) begin
        row_d = row_q + RW'(1);
        col_d = '0;
      end else begin
        col_d = col_q + CW'(1);
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.kind == KIND_LOAD) begin
            for (int r = 0; r < ROWS; r++) begin
              if (32'(req_i.row_index) == r) begin
                map_d[r*COLS +: COLS] = row_val;
              end
            end
          end else begin
            row_d = '0;
            col_d = '0;
            count_d = '0;
            hit_d = 1'b0;
            mark_d = 1'b0;
            srow_d = '0;
            scol_d = '0;
            size_d = req_i.request_size;
          end
        end
      end
      ST_SEARCH: begin
        map_d = (map_q >> 1) | (TOTAL'(map_q[0]) << (TOTAL - 1));
        if (!hit_q) begin
          if (map_q[0]) begin
            count_d = '0;
          end else begin
            if (count_q == '0) begin
              srow_d = row_q;
              scol_d = col_q;
            end
            count_d = count_inc[CNT_W-1:0];
            if (hit_now) begin
              hit_d = 1'b1;
              erow_d = row_q;
              ecol_d = col_q;
            end
          end
        end
      end
      ST_MARK: begin
        map_d = (map_q >> 1) | (TOTAL'(map_q[0] | in_run) << (TOTAL - 1));
        mark_d = in_run && !at_end;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign srow_wide = 64'(srow_q);
  assign scol_wide = 64'(scol_q);

  always_comb begin
    rsp_o.found = hit_q;
    rsp_o.start_row = hit_q ? srow_wide[POS_W-1:0] : '0;
    rsp_o.start_column = hit_q ? scol_wide[POS_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      map_q <= '0;
      row_q <= '0;
      col_q <= '0;
      count_q <= '0;
      hit_q <= 1'b0;
      mark_q <= 1'b0;
    end else begin
      state_q <= state_d;
      map_q <= map_d;
      row_q <= row_d;
      col_q <= col_d;
      count_q <= count_d;
      hit_q <= hit_d;
      mark_q <= mark_d;
    end
  end

  always_ff @(posedge clk_i) begin
    srow_q <= srow_d;
    scol_q <= scol_d;
    erow_q <= erow_d;
    ecol_q <= ecol_d;
    size_q <= size_d;
  end

endmodule

### sim/bitmap_first_fit_allocator_test.sv
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator testbench
// Drives row loads and allocation requests into the allocator and checks
// every grant against a behavioral model of the block map. A short directed
// part covers size limits, a full map, runs across row boundaries and
// fragmented rows. Random episodes of loads followed by allocations, and
// random noise items, follow with bursty request timing.
// ----------------------------------------------------------------------------

module bitmap_first_fit_allocator_test;
  import bffa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROWS = DEF_ROWS;
  localparam int unsigned COLS = DEF_COLS;
  localparam int unsigned MAP_BITS = ROWS * COLS;
  localparam int unsigned RI_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CI_W = (COLS > 1) ? $clog2(COLS) : 1;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  alloc_req_t req;
  logic       busy;
  logic       done_o;
  alloc_rsp_t rsp;

  logic [COLS-1:0] block_map_model [ROWS];
  alloc_rsp_t      expected_grants [$];
  int unsigned     error_count;
  int unsigned     items_sent;
  bit              pacing_on;
  int unsigned     burst_left;

  bitmap_first_fit_allocator #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .req_i (req),
    .busy  (busy),
    .done_o(done_o),
    .rsp_o (rsp)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #15_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic alloc_req_t make_load(input int unsigned row, input logic [15:0] bits);
    alloc_req_t item;
    item = '0;
    item.kind = KIND_LOAD;
    item.row_index = ROW_IDX_W'(row);
    item.row_bits = bits;
    item.request_size = SIZE_W'($urandom);
    return item;
  endfunction

  function automatic alloc_req_t make_alloc(input logic [SIZE_W-1:0] size);
    alloc_req_t item;
    item = '0;
    item.kind = KIND_ALLOC;
    item.row_index = ROW_IDX_W'($urandom);
    item.row_bits = ROW_BITS_W'($urandom);
    item.request_size = size;
    return item;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return SIZE_W'($urandom_range(1, 24));
    if (roll < 85) return SIZE_W'($urandom_range(25, MAP_BITS));
    if (roll < 92) return '0;
    return SIZE_W'($urandom_range(MAP_BITS + 1, 511));
  endfunction

  // First-fit search in row-major order; runs may cross row boundaries.
  function automatic alloc_rsp_t predict_grant(input logic [SIZE_W-1:0] size);
    alloc_rsp_t  grant;
    int unsigned run_len;
    int unsigned run_first;
    int unsigned pos;
    grant = '0;
    if (size == 0 || size > MAP_BITS) return grant;
    run_len = 0;
    run_first = 0;
    for (pos = 0; pos < MAP_BITS; pos++) begin
      if (block_map_model[RI_W'(pos / COLS)][CI_W'(pos % COLS)]) begin
        run_len = 0;
      end else begin
        if (run_len == 0) run_first = pos;
        run_len++;
        if (run_len == size) break;
      end
    end
    if (run_len != size) return grant;
    for (pos = run_first; pos < run_first + size; pos++) begin
      block_map_model[RI_W'(pos / COLS)][CI_W'(pos % COLS)] = 1'b1;
    end
    grant.found = 1'b1;
    grant.start_row = POS_W'(run_first / COLS);
    grant.start_column = POS_W'(run_first % COLS);
    return grant;
  endfunction

  task automatic issue_request(input alloc_req_t item);
    if (pacing_on) begin
      if (burst_left == 0) begin
        @(negedge clk_i);
        start <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) :
                                                   $urandom_range(1, 12);
      end
      burst_left--;
    end
    @(negedge clk_i);
    start <= 1'b1;
    req <= item;
    do @(posedge clk_i); while (busy);
    items_sent++;
    if (item.kind == KIND_LOAD) begin
      if (item.row_index < ROWS) block_map_model[item.row_index] = item.row_bits;
    end else begin
      expected_grants.push_back(predict_grant(item.request_size));
    end
  endtask

  always @(posedge clk_i) begin
    alloc_rsp_t want;
    if (rst_ni && done_o) begin
      if (expected_grants.size() == 0) begin
        $error("unexpected result transfer: found=%0d row=%0d column=%0d",
               rsp.found, rsp.start_row, rsp.start_column);
        error_count++;
      end else begin
        want = expected_grants.pop_front();
        if (rsp.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, rsp.found);
          error_count++;
        end
        if (rsp.start_row !== want.start_row) begin
          $error("start_row: expected %0d, got %0d", want.start_row, rsp.start_row);
          error_count++;
        end
        if (rsp.start_column !== want.start_column) begin
          $error("start_column: expected %0d, got %0d", want.start_column,
                 rsp.start_column);
          error_count++;
        end
      end
    end
  end

  task automatic test_size_limits();
    issue_request(make_alloc(9'd0));
    issue_request(make_alloc(9'd511));
    issue_request(make_alloc(SIZE_W'(MAP_BITS + 1)));
  endtask

  task automatic test_full_map();
    issue_request(make_alloc(SIZE_W'(MAP_BITS)));
    issue_request(make_alloc(9'd1));
    issue_request(make_load(15, 16'h0000));
    issue_request(make_alloc(9'd17));
    issue_request(make_alloc(9'd16));
  endtask

  task automatic test_row_crossing();
    issue_request(make_load(3, 16'h7fff));
    issue_request(make_load(4, 16'hfffe));
    issue_request(make_alloc(9'd2));
  endtask

  task automatic test_fragmented_rows();
    issue_request(make_load(7, 16'h5555));
    issue_request(make_alloc(9'd2));
    issue_request(make_alloc(9'd1));
    issue_request(make_load(0, 16'h0000));
    issue_request(make_alloc(SIZE_W'(MAP_BITS - 1)));
    issue_request(make_alloc(9'd16));
  endtask

  // Episodes reload random rows with bits of a random density, then issue one to eight allocations.
  task automatic test_alloc_episodes();
    int unsigned     density;
    logic [COLS-1:0] bits;
    while (items_sent < 420) begin
      density = $urandom_range(0, 3);
      repeat ($urandom_range(1, 16)) begin
        case (density)
          0: bits = '0;
          1: bits = COLS'($urandom & $urandom & $urandom);
          2: bits = COLS'($urandom & $urandom);
          default: bits = COLS'($urandom);
        endcase
        issue_request(make_load($urandom_range(0, ROWS - 1), 16'(bits)));
      end
      repeat ($urandom_range(1, 8)) issue_request(make_alloc(pick_size()));
    end
  endtask

  task automatic test_random_noise();
    int unsigned stop_at;
    stop_at = items_sent + 130;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 1) == 0) begin
        issue_request(make_load($urandom_range(0, 15), 16'($urandom)));
      end else begin
        issue_request(make_alloc(pick_size()));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req = '0;
    error_count = 0;
    items_sent = 0;
    pacing_on = 1'b0;
    burst_left = 0;
    block_map_model = '{default: '0};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_size_limits();
    test_full_map();
    test_row_crossing();
    test_fragmented_rows();
    pacing_on = 1'b1;
    test_alloc_episodes();
    test_random_noise();

    @(negedge clk_i);
    start <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk_i);
    repeat (2 * MAP_BITS + 8) @(posedge clk_i);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
sv/bffa_pkg.sv
sv/bitmap_first_fit_allocator.sv
sim/bitmap_first_fit_allocator_test.sv
